### rtl/core/byte_deque_with_search_core_defines.svh
// Assertion macros used by the checker file of the byte deque core.
// Each macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef BYTE_DEQUE_WITH_SEARCH_CORE_DEFINES_SVH
`define BYTE_DEQUE_WITH_SEARCH_CORE_DEFINES_SVH

`define BDQS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define BDQS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/bdqs_pkg.sv
package bdqs_pkg;

   localparam int CAPACITY_DEFAULT = 64;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_SEARCH     = 3'd4,
      OP_CLEAR      = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      RS_OK    = 2'd0,
      RS_FULL  = 2'd1,
      RS_EMPTY = 2'd2
   } result_status_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_READ   = 4'b0010,
      ST_SEARCH = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   typedef struct packed {
      logic accept;
      logic pop_finish;
      logic srch_run;
      logic srch_finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_read;
      logic need_search;
      logic match;
      logic exhausted;
   } dp_status_type;

endpackage

### rtl/core/bdqs_if.sv
interface bdqs_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] req_type;
   logic [7:0] item_value;

   modport source (output valid, output req_type, output item_value, input ready);
   modport sink (input valid, input req_type, input item_value, output ready);
endinterface

interface bdqs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_value;
   logic       found;
   logic [5:0] position;
   logic [6:0] count;
   logic [1:0] status;

   modport source (output valid, output out_value, output found, output position,
                   output count, output status, input ready);
   modport sink (input valid, input out_value, input found, input position,
                 input count, input status, output ready);
endinterface

### rtl/core/bdqs_ram.sv
module bdqs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/bdqs_ctrl.sv
module bdqs_ctrl import bdqs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type dp_status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (dp_status.need_read) begin
                  state_in = ST_READ;
               end else if (dp_status.need_search) begin
                  state_in = ST_SEARCH;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_READ: begin
            cmd.pop_finish = 1'b1;
            state_in       = ST_DONE;
         end
         ST_SEARCH: begin
            cmd.srch_run = 1'b1;
            if (dp_status.match || dp_status.exhausted) begin
               cmd.srch_finish = 1'b1;
               state_in        = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/bdqs_dpath.sv
module bdqs_dpath import bdqs_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   output dp_status_type dp_status,
   input  logic [2:0]    req_type,
   input  logic [7:0]    item_value,
   output logic [7:0]    out_value,
   output logic          found,
   output logic [5:0]    position,
   output logic [6:0]    count,
   output logic [1:0]    status
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int SW = CW + 1;

   function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
                                              input logic [CW-1:0] off);
      logic [SW-1:0] sum;
      sum = {{(SW-IW){1'b0}}, base} + {1'b0, off};
      if (sum >= SW'(CAPACITY)) begin
         sum = sum - SW'(CAPACITY);
      end
      return sum[IW-1:0];
   endfunction

   logic [IW-1:0] front_ff, front_in;
   logic [CW-1:0] count_ff, count_in;
   logic          pend_ff;
   logic [CW-1:0] pend_idx_ff;
   logic [CW-1:0] scan_ff;
   logic [7:0]    val_ff;
   logic [7:0]    out_value_ff;
   logic          found_ff;
   logic [IW-1:0] pos_ff;
   result_status_type status_ff, status_in;

   logic          full, empty;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [IW-1:0] prev_front;
   logic [IW-1:0] pop_addr;
   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic [7:0]    rd_data;
   logic          scan_live;
   logic [IW+5:0] pos_ext;
   logic [CW+6:0] count_ext;

   assign full       = (count_ff == CW'(CAPACITY));
   assign empty      = (count_ff == '0);
   assign prev_front = (front_ff == '0) ? IW'(CAPACITY - 1) : front_ff - 1'b1;
   assign scan_live  = (scan_ff < count_ff);

   always_comb begin
      front_in              = front_ff;
      count_in              = count_ff;
      status_in             = RS_OK;
      wr_en                 = 1'b0;
      wr_addr               = ring_add(front_ff, count_ff);
      pop_addr              = front_ff;
      dp_status.need_read   = 1'b0;
      dp_status.need_search = 1'b0;
      dp_status.match       = pend_ff && (rd_data == val_ff);
      dp_status.exhausted   = pend_ff && (pend_idx_ff == count_ff - 1'b1);
      case (op_type'(req_type))
         OP_PUSH_FRONT: begin
            if (full) begin
               status_in = RS_FULL;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = prev_front;
               front_in = prev_front;
               count_in = count_ff + 1'b1;
            end
         end
         OP_PUSH_BACK: begin
            if (full) begin
               status_in = RS_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               status_in = RS_EMPTY;
            end else begin
               dp_status.need_read = 1'b1;
               front_in            = ring_add(front_ff, CW'(1));
               count_in            = count_ff - 1'b1;
            end
         end
         OP_POP_BACK: begin
            if (empty) begin
               status_in = RS_EMPTY;
            end else begin
               dp_status.need_read = 1'b1;
               pop_addr            = ring_add(front_ff, count_ff - 1'b1);
               count_in            = count_ff - 1'b1;
            end
         end
         OP_SEARCH: begin
            dp_status.need_search = !empty;
         end
         OP_CLEAR: begin
            front_in = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   assign rd_en   = (cmd.accept && dp_status.need_read) || cmd.srch_run;
   assign rd_addr = cmd.accept ? pop_addr : ring_add(front_ff, scan_ff);

   bdqs_ram #(
      .WIDTH (8),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.accept && wr_en),
      .wr_addr (wr_addr),
      .wr_data (item_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         if (cmd.accept) begin
            front_ff <= front_in;
            count_ff <= count_in;
            pend_ff  <= 1'b0;
         end
         if (cmd.srch_run) begin
            pend_ff <= scan_live;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         val_ff       <= item_value;
         out_value_ff <= '0;
         found_ff     <= 1'b0;
         pos_ff       <= '0;
         status_ff    <= status_in;
         scan_ff      <= '0;
      end
      if (cmd.pop_finish) begin
         out_value_ff <= rd_data;
      end
      if (cmd.srch_run) begin
         pend_idx_ff <= scan_ff;
         if (scan_live) begin
            scan_ff <= scan_ff + 1'b1;
         end
      end
      if (cmd.srch_finish) begin
         found_ff <= dp_status.match;
         pos_ff   <= dp_status.match ? pend_idx_ff[IW-1:0] : '0;
      end
   end

   assign pos_ext   = {6'b0, pos_ff};
   assign count_ext = {7'b0, count_ff};

   assign out_value = out_value_ff;
   assign found     = found_ff;
   assign position  = pos_ext[5:0];
   assign count     = count_ext[6:0];
   assign status    = status_ff;

endmodule

### rtl/core/byte_deque_with_search_core.sv
// Sequence: a push, a clear, a failed push or pop, or a search of an empty store goes from
// acceptance straight to the done state; a pop passes through the read state, and a search
// through the search state, scanning from the front until a match or the last stored byte.
// Throughput: one transaction at a time, the next is accepted the cycle after the result is
// taken; the search rate is one stored byte per cycle through the single store read port.
// Reset (synchronous): front index, count and controller clear; stored bytes are not cleared.
module byte_deque_with_search_core import bdqs_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   bdqs_req_if.sink  req_bus,
   bdqs_rsp_if.source rsp_bus
);

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   bdqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   bdqs_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .dp_status  (dp_status),
      .req_type   (req_bus.req_type),
      .item_value (req_bus.item_value),
      .out_value  (rsp_bus.out_value),
      .found      (rsp_bus.found),
      .position   (rsp_bus.position),
      .count      (rsp_bus.count),
      .status     (rsp_bus.status)
   );

endmodule

### rtl/core/bdqs_checker.sv
`include "byte_deque_with_search_core_defines.svh"

module bdqs_checker import bdqs_pkg::*; (
   input logic        clock,
   input logic        reset,
   bdqs_req_if.sink   req_bus,
   bdqs_rsp_if.source rsp_bus
);

   // Only one transaction is in flight, so no request is taken while a result waits.
   `BDQS_ASSERT_SAME(a_no_overlap, rsp_bus.valid, !req_bus.ready, "request taken while result pending")

   `BDQS_ASSERT_SAME(a_error_fields_zero, rsp_bus.valid && (rsp_bus.status != RS_OK), (rsp_bus.found == 1'b0) && (rsp_bus.position == '0) && (rsp_bus.out_value == '0), "error result carries data")

   `BDQS_ASSERT_SAME(a_position_needs_hit, rsp_bus.valid && !rsp_bus.found, rsp_bus.position == '0, "position set without a match")

   `BDQS_ASSERT_NEXT(a_rsp_hold, rsp_bus.valid && !rsp_bus.ready, rsp_bus.valid && $stable(rsp_bus.out_value) && $stable(rsp_bus.found) && $stable(rsp_bus.position) && $stable(rsp_bus.count) && $stable(rsp_bus.status), "stalled result changed")

endmodule

bind byte_deque_with_search_core bdqs_checker u_bdqs_checker (
   .clock   (clock),
   .reset   (reset),
   .req_bus (req_bus),
   .rsp_bus (rsp_bus)
);
